/* hw/rtl/npcm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_pkg: shared types and constants for the nearest palette color mapper
// Channel and field widths, register map and the candidate beat that moves
// along the cell chain.
// ----------------------------------------------------------------------------
package npcm_pkg;

    localparam int PALETTE_SIZE_DEF = 8;   // default number of compare cells
    localparam int MAX_ENTRIES      = 8;   // entries the register file holds
    localparam int PAIR_COUNT       = 4;
    localparam int CH_W             = 8;
    localparam int COLOR_W          = 3 * CH_W;
    localparam int PAIR_W           = 2 * COLOR_W;
    localparam int IDX_W            = 3;
    localparam int NUM_W            = 4;
    localparam int SQ_W             = 2 * CH_W;
    localparam int DIST_W           = 18;
    localparam int DATA_W           = 64;
    localparam int ADDR_W           = 6;

    // one above the largest possible squared distance (3 * 255 * 255)
    localparam logic [DIST_W-1:0] DIST_START = DIST_W'(3 * 255 * 255 + 1);

    typedef enum logic [2:0] {
        REG_PAIR_0     = 3'd0,
        REG_PAIR_1     = 3'd1,
        REG_PAIR_2     = 3'd2,
        REG_PAIR_3     = 3'd3,
        REG_NUM_COLORS = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [MAX_ENTRIES-1:0][COLOR_W-1:0] palette;
        logic [NUM_W-1:0]                    num_colors;
    } cfg_t;

    typedef struct packed {
        logic [CH_W-1:0]   red;
        logic [CH_W-1:0]   green;
        logic [CH_W-1:0]   blue;
        logic [DIST_W-1:0] best_dist;
        logic [IDX_W-1:0]  pick;
    } cand_t;

endpackage
`default_nettype wire

/* hw/rtl/npcm_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_regs: configuration register file
// APB-style write and read of four palette pair registers and the active
// color count; presents the unpacked palette to the cell chain.
// ----------------------------------------------------------------------------
module npcm_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [npcm_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [npcm_pkg::DATA_W-1:0]   pwdata,
    output logic      [npcm_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output npcm_pkg::cfg_t                     cfg
);

    logic [npcm_pkg::PAIR_W-1:0] pair_reg  [npcm_pkg::PAIR_COUNT];
    logic [npcm_pkg::PAIR_W-1:0] pair_next [npcm_pkg::PAIR_COUNT];
    logic [npcm_pkg::NUM_W-1:0]  num_colors_reg;
    logic [npcm_pkg::NUM_W-1:0]  num_colors_next;
    logic                        wr_en;
    npcm_pkg::reg_idx_t          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = npcm_pkg::reg_idx_t'(paddr[npcm_pkg::ADDR_W-1:3]);

    always_comb
    begin
        for (int p = 0; p < npcm_pkg::PAIR_COUNT; p++)
        begin
            pair_next[p] = pair_reg[p];
        end
        num_colors_next = num_colors_reg;
        if (wr_en)
        begin
            case (reg_idx)
                npcm_pkg::REG_PAIR_0:     pair_next[0] = pwdata[npcm_pkg::PAIR_W-1:0];
                npcm_pkg::REG_PAIR_1:     pair_next[1] = pwdata[npcm_pkg::PAIR_W-1:0];
                npcm_pkg::REG_PAIR_2:     pair_next[2] = pwdata[npcm_pkg::PAIR_W-1:0];
                npcm_pkg::REG_PAIR_3:     pair_next[3] = pwdata[npcm_pkg::PAIR_W-1:0];
                npcm_pkg::REG_NUM_COLORS: num_colors_next = pwdata[npcm_pkg::NUM_W-1:0];
                default:                  ;  // drop writes to unmapped addresses
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < npcm_pkg::PAIR_COUNT; p++)
            begin
                pair_reg[p] <= '0;
            end
            num_colors_reg <= '0;
        end
        else
        begin
            for (int p = 0; p < npcm_pkg::PAIR_COUNT; p++)
            begin
                pair_reg[p] <= pair_next[p];
            end
            num_colors_reg <= num_colors_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            npcm_pkg::REG_PAIR_0:     prdata = npcm_pkg::DATA_W'(pair_reg[0]);
            npcm_pkg::REG_PAIR_1:     prdata = npcm_pkg::DATA_W'(pair_reg[1]);
            npcm_pkg::REG_PAIR_2:     prdata = npcm_pkg::DATA_W'(pair_reg[2]);
            npcm_pkg::REG_PAIR_3:     prdata = npcm_pkg::DATA_W'(pair_reg[3]);
            npcm_pkg::REG_NUM_COLORS: prdata = npcm_pkg::DATA_W'(num_colors_reg);
            default:                  prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int p = 0; p < npcm_pkg::PAIR_COUNT; p++)
        begin
            cfg.palette[2*p]   = pair_reg[p][npcm_pkg::COLOR_W-1:0];
            cfg.palette[2*p+1] = pair_reg[p][npcm_pkg::PAIR_W-1:npcm_pkg::COLOR_W];
        end
        cfg.num_colors = num_colors_reg;
    end

endmodule
`default_nettype wire

/* hw/rtl/npcm_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// npcm_cell: one palette compare cell
// Stage A squares the channel differences against this cell's entry; stage B
// sums them and, if enabled, keeps the nearer of incoming best and this entry.
// ----------------------------------------------------------------------------
module npcm_cell #(
    parameter int CELL_INDEX = 0
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cell_en,
    input  wire logic [npcm_pkg::COLOR_W-1:0]   entry_color,
    input  wire logic                           in_valid,
    input  npcm_pkg::cand_t                     in_cand,
    output logic                                out_valid,
    output npcm_pkg::cand_t                     out_cand
);

    logic [npcm_pkg::CH_W-1:0] entry_r;
    logic [npcm_pkg::CH_W-1:0] entry_g;
    logic [npcm_pkg::CH_W-1:0] entry_b;
    logic [npcm_pkg::CH_W-1:0] diff_r;
    logic [npcm_pkg::CH_W-1:0] diff_g;
    logic [npcm_pkg::CH_W-1:0] diff_b;

    logic [npcm_pkg::SQ_W-1:0] sq_r_reg;
    logic [npcm_pkg::SQ_W-1:0] sq_g_reg;
    logic [npcm_pkg::SQ_W-1:0] sq_b_reg;
    npcm_pkg::cand_t           cand_a_reg;
    logic                      valid_a_reg;

    logic [npcm_pkg::DIST_W-1:0] dist_sum;
    npcm_pkg::cand_t             cand_b_next;
    npcm_pkg::cand_t             cand_b_reg;
    logic                        valid_b_reg;

    assign entry_r = entry_color[3*npcm_pkg::CH_W-1:2*npcm_pkg::CH_W];
    assign entry_g = entry_color[2*npcm_pkg::CH_W-1:npcm_pkg::CH_W];
    assign entry_b = entry_color[npcm_pkg::CH_W-1:0];

    assign diff_r = (in_cand.red > entry_r)   ? in_cand.red - entry_r   : entry_r - in_cand.red;
    assign diff_g = (in_cand.green > entry_g) ? in_cand.green - entry_g : entry_g - in_cand.green;
    assign diff_b = (in_cand.blue > entry_b)  ? in_cand.blue - entry_b  : entry_b - in_cand.blue;

    always_ff @(posedge clk)
    begin
        sq_r_reg   <= diff_r * diff_r;
        sq_g_reg   <= diff_g * diff_g;
        sq_b_reg   <= diff_b * diff_b;
        cand_a_reg <= in_cand;
    end

    assign dist_sum = npcm_pkg::DIST_W'(sq_r_reg) + npcm_pkg::DIST_W'(sq_g_reg)
                    + npcm_pkg::DIST_W'(sq_b_reg);

    // strict less-than keeps the lower index on a tie
    always_comb
    begin
        cand_b_next = cand_a_reg;
        if (cell_en && (dist_sum < cand_a_reg.best_dist))
        begin
            cand_b_next.best_dist = dist_sum;
            cand_b_next.pick      = npcm_pkg::IDX_W'(CELL_INDEX);
        end
    end

    always_ff @(posedge clk)
    begin
        cand_b_reg <= cand_b_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_cand  = cand_b_reg;

endmodule
`default_nettype wire

/* hw/rtl/nearest_palette_color_mapper_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper_top: nearest palette color quantizer
// Path: start to done runs through stage A and stage B of every compare
//   cell in turn, then through the output register.
// Throughput: one pixel per cycle; busy stays low, the cell chain takes a
//   new beat every cycle and done cannot be stalled by the receiver.
// Reset: clears all valid bits and the configuration registers to zero.
// ----------------------------------------------------------------------------
module nearest_palette_color_mapper_top #(
    parameter int PALETTE_SIZE = npcm_pkg::PALETTE_SIZE_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [npcm_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [npcm_pkg::DATA_W-1:0]   pwdata,
    output logic      [npcm_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [npcm_pkg::CH_W-1:0]     red_in,
    input  wire logic [npcm_pkg::CH_W-1:0]     green_in,
    input  wire logic [npcm_pkg::CH_W-1:0]     blue_in,
    output logic                               done,
    output logic      [npcm_pkg::CH_W-1:0]     red_out,
    output logic      [npcm_pkg::CH_W-1:0]     green_out,
    output logic      [npcm_pkg::CH_W-1:0]     blue_out,
    output logic      [npcm_pkg::IDX_W-1:0]    entry_index
);

    localparam int LATENCY = 2 * PALETTE_SIZE + 1;

    npcm_pkg::cfg_t  cfg;
    npcm_pkg::cand_t chain_cand  [PALETTE_SIZE+1];
    logic            chain_valid [PALETTE_SIZE+1];

    logic [npcm_pkg::COLOR_W-1:0] pick_color;
    logic                         done_reg;
    logic [npcm_pkg::CH_W-1:0]    red_reg;
    logic [npcm_pkg::CH_W-1:0]    green_reg;
    logic [npcm_pkg::CH_W-1:0]    blue_reg;
    logic [npcm_pkg::IDX_W-1:0]   index_reg;

    npcm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign busy = 1'b0;

    // seed the chain with the pixel and a distance no entry can reach
    assign chain_valid[0]          = start & ~busy;
    assign chain_cand[0].red       = red_in;
    assign chain_cand[0].green     = green_in;
    assign chain_cand[0].blue      = blue_in;
    assign chain_cand[0].best_dist = npcm_pkg::DIST_START;
    assign chain_cand[0].pick      = '0;

    for (genvar i = 0; i < PALETTE_SIZE; i++)
    begin : g_cell
        npcm_cell #(
            .CELL_INDEX (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cell_en     (cfg.num_colors > npcm_pkg::NUM_W'(i)),
            .entry_color (cfg.palette[i]),
            .in_valid    (chain_valid[i]),
            .in_cand     (chain_cand[i]),
            .out_valid   (chain_valid[i+1]),
            .out_cand    (chain_cand[i+1])
        );
    end

    assign pick_color = cfg.palette[chain_cand[PALETTE_SIZE].pick];

    always_ff @(posedge clk)
    begin
        red_reg   <= pick_color[3*npcm_pkg::CH_W-1:2*npcm_pkg::CH_W];
        green_reg <= pick_color[2*npcm_pkg::CH_W-1:npcm_pkg::CH_W];
        blue_reg  <= pick_color[npcm_pkg::CH_W-1:0];
        index_reg <= chain_cand[PALETTE_SIZE].pick;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain_valid[PALETTE_SIZE];
        end
    end

    assign done        = done_reg;
    assign red_out     = red_reg;
    assign green_out   = green_reg;
    assign blue_out    = blue_reg;
    assign entry_index = index_reg;

    a_fixed_latency : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted pixel did not produce a beat after the fixed latency");

    a_no_stray_done : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("done beat without a matching accepted pixel");

    a_index_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ({1'b0, entry_index} < (npcm_pkg::IDX_W + 1)'(PALETTE_SIZE)))
        else $error("picked entry lies beyond the compare cells");

    a_empty_palette : assert property (@(posedge clk) disable iff (!rst_n)
        (done && cfg.num_colors == '0) |-> (entry_index == '0))
        else $error("empty palette must pick entry zero");

endmodule
`default_nettype wire

/* verif/nearest_palette_color_mapper_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_palette_color_mapper_top_test: self-checking bench for the mapper
// Programs palettes and color counts over the register port, streams pixels
// and checks every returned color and index against a predictor that runs
// the same nearest-entry search with the lowest index winning on ties.
// ----------------------------------------------------------------------------
module nearest_palette_color_mapper_top_test;

    localparam int PALETTE_N     = npcm_pkg::PALETTE_SIZE_DEF;
    localparam int RANDOM_PHASES = 30;
    localparam int PIXELS_PER_PHASE = 35;
    localparam int FIRST_UNUSED_REG = int'(npcm_pkg::REG_NUM_COLORS) + 1;
    localparam int LAST_REG_SLOT  = (1 << npcm_pkg::ADDR_W) / 8 - 1;
    localparam int DRAIN_CYCLES   = 2 * PALETTE_N + 8;
    localparam int CYCLE_LIMIT    = 400000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [npcm_pkg::CH_W-1:0] red;
        logic [npcm_pkg::CH_W-1:0] green;
        logic [npcm_pkg::CH_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [npcm_pkg::CH_W-1:0]  red;
        logic [npcm_pkg::CH_W-1:0]  green;
        logic [npcm_pkg::CH_W-1:0]  blue;
        logic [npcm_pkg::IDX_W-1:0] index;
    } mapped_color_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [npcm_pkg::ADDR_W-1:0] paddr = '0;
    logic [npcm_pkg::DATA_W-1:0] pwdata = '0;
    logic [npcm_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic [npcm_pkg::CH_W-1:0] red_in = '0;
    logic [npcm_pkg::CH_W-1:0] green_in = '0;
    logic [npcm_pkg::CH_W-1:0] blue_in = '0;
    logic done;
    logic [npcm_pkg::CH_W-1:0] red_out;
    logic [npcm_pkg::CH_W-1:0] green_out;
    logic [npcm_pkg::CH_W-1:0] blue_out;
    logic [npcm_pkg::IDX_W-1:0] entry_index;

    // shadow of the block's registers
    logic [npcm_pkg::PAIR_W-1:0]  pal_pairs [npcm_pkg::PAIR_COUNT];
    logic [npcm_pkg::NUM_W-1:0]   ncolors;
    logic [npcm_pkg::COLOR_W-1:0] new_colors [npcm_pkg::MAX_ENTRIES];

    pixel_t        pending_pixels [$];
    mapped_color_t expected_colors [$];
    pixel_t        next_pix;

    bit took = 1'b0;
    int sender_gap_pct = 8;
    int pixels_loaded = 0;
    int pixels_accepted = 0;
    int checked_count = 0;
    int mismatch_count = 0;
    int cycle_count = 0;
    int settings_count = 0;

    nearest_palette_color_mapper_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .start       (start),
        .busy        (busy),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .done        (done),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .entry_index (entry_index)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic logic [npcm_pkg::COLOR_W-1:0] palette_color(input int e);
        logic [npcm_pkg::PAIR_W-1:0] pair;
        pair = pal_pairs[(e >> 1) % npcm_pkg::PAIR_COUNT];
        return (e % 2 == 1) ? pair[npcm_pkg::PAIR_W-1:npcm_pkg::COLOR_W]
                            : pair[npcm_pkg::COLOR_W-1:0];
    endfunction

    function automatic mapped_color_t nearest_entry(input pixel_t pix);
        int n;
        int e;
        int best;
        int pick;
        int dr;
        int dg;
        int db;
        logic [npcm_pkg::COLOR_W-1:0] col;
        mapped_color_t res;
        n = (int'(ncolors) > PALETTE_N) ? PALETTE_N : int'(ncolors);
        best = 3 * 255 * 255 + 1;
        pick = 0;
        for (e = 0; e < n; e++)
        begin
            col = palette_color(e);
            dr = int'(pix.red) - int'(col[23:16]);
            dg = int'(pix.green) - int'(col[15:8]);
            db = int'(pix.blue) - int'(col[7:0]);
            if (dr * dr + dg * dg + db * db < best)
            begin
                best = dr * dr + dg * dg + db * db;
                pick = e;
            end
        end
        col = palette_color(pick);
        res.red = col[23:16];
        res.green = col[15:8];
        res.blue = col[7:0];
        res.index = npcm_pkg::IDX_W'(pick);
        return res;
    endfunction

    function automatic logic [npcm_pkg::CH_W-1:0] nudge(input logic [npcm_pkg::CH_W-1:0] ch);
        int v;
        v = int'(ch) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return npcm_pkg::CH_W'(v);
    endfunction

    // driver: present the next pixel once the current beat is taken
    always @(negedge clk)
    begin
        if (!start || took)
        begin
            if (rst_n && pending_pixels.size() != 0
                && $urandom_range(0, 99) >= sender_gap_pct)
            begin
                next_pix = pending_pixels.pop_front();
                start <= 1'b1;
                red_in <= next_pix.red;
                green_in <= next_pix.green;
                blue_in <= next_pix.blue;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    task automatic note_mismatch(input string what, input mapped_color_t want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch (%s) at cycle %0d: expected %h %h %h idx %0d, got %h %h %h idx %0d",
                     what, cycle_count, want.red, want.green, want.blue, want.index,
                     red_out, green_out, blue_out, entry_index);
    endtask

    // monitor: check results first, then record the beat taken at this edge
    always @(posedge clk)
    begin
        mapped_color_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
        took = rst_n && start && !busy;
        if (rst_n && done === 1'b1)
        begin
            if (expected_colors.size() == 0)
            begin
                want = '0;
                note_mismatch("unexpected result", want);
            end
            else
            begin
                want = expected_colors.pop_front();
                checked_count++;
                if (red_out !== want.red || green_out !== want.green
                    || blue_out !== want.blue || entry_index !== want.index)
                    note_mismatch("wrong field", want);
            end
        end
        if (took)
        begin
            expected_colors.push_back(nearest_entry('{red_in, green_in, blue_in}));
            pixels_accepted++;
        end
    end

    task automatic write_reg(input int idx, input logic [npcm_pkg::DATA_W-1:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= npcm_pkg::ADDR_W'(idx * 8);
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (idx < npcm_pkg::PAIR_COUNT)
            pal_pairs[idx] = data[npcm_pkg::PAIR_W-1:0];
        else if (idx == int'(npcm_pkg::REG_NUM_COLORS))
            ncolors = data[npcm_pkg::NUM_W-1:0];
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // upper 16 bits of each pair carry junk that the block must drop
    task automatic write_palette(input bit every_pair);
        int k;
        for (k = 0; k < npcm_pkg::PAIR_COUNT; k++)
            if (every_pair || $urandom_range(0, 3) != 0)
                write_reg(int'(npcm_pkg::REG_PAIR_0) + k,
                          {16'($urandom), new_colors[2*k+1], new_colors[2*k]});
        settings_count++;
    endtask

    task automatic add_pixel(input logic [npcm_pkg::COLOR_W-1:0] rgb);
        pending_pixels.push_back(rgb);
        pixels_loaded++;
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pixels_accepted != pixels_loaded || expected_colors.size() != 0);
    endtask

    initial
    begin
        int phase;
        int style;
        int i;
        int mode;
        int pick;
        logic [3:0] cnt;
        logic [npcm_pkg::COLOR_W-1:0] base [3];
        logic [npcm_pkg::COLOR_W-1:0] col;

        for (i = 0; i < npcm_pkg::PAIR_COUNT; i++)
            pal_pairs[i] = '0;
        ncolors = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // reset palette: everything maps to black entry 0
        add_pixel(24'h000000);
        add_pixel(24'hFFFFFF);
        add_pixel(24'h5AA53C);
        wait_drained();

        // corners, duplicates and equidistant pixels
        new_colors[0] = 24'h000000;
        new_colors[1] = 24'hFFFFFF;
        new_colors[2] = 24'hFF0000;
        new_colors[3] = 24'h00FF00;
        new_colors[4] = 24'h0000FF;
        new_colors[5] = 24'hFFFF00;
        new_colors[6] = 24'h808080;
        new_colors[7] = 24'h808080;
        write_palette(1'b1);
        write_reg(int'(npcm_pkg::REG_NUM_COLORS), 64'h8);
        for (i = FIRST_UNUSED_REG; i <= LAST_REG_SLOT; i++)
            write_reg(i, '1);
        add_pixel(24'h000000);
        add_pixel(24'hFFFFFF);
        add_pixel(24'hFF0000);
        add_pixel(24'h00FFFF);
        add_pixel(24'h808080);
        add_pixel(24'h7F7F7F);
        add_pixel(24'hFEFEFE);
        add_pixel(24'h010000);
        add_pixel(24'hFFFF00);
        add_pixel(24'h0000FF);
        wait_drained();

        // count above the palette size clamps to the full palette
        write_reg(int'(npcm_pkg::REG_NUM_COLORS), '1);
        add_pixel(24'h808080);
        add_pixel(24'h00FFFF);
        add_pixel(24'h10F010);
        wait_drained();

        write_reg(int'(npcm_pkg::REG_NUM_COLORS), 64'hFFFF_FFFF_FFFF_FFF1);
        add_pixel(24'hFFFFFF);
        add_pixel(24'h123456);
        wait_drained();

        // no colors in use: entry 0 regardless of the pixel
        write_reg(int'(npcm_pkg::REG_PAIR_0), {16'hA5A5, 24'hFFFFFF, 24'h3C96F0});
        write_reg(int'(npcm_pkg::REG_NUM_COLORS), 64'h0);
        add_pixel(24'h3C96F0);
        add_pixel(24'h000000);
        wait_drained();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            sender_gap_pct = (phase < RANDOM_PHASES / 3) ? 8 :
                             (phase < 2 * RANDOM_PHASES / 3) ? 81 : 0;
            style = $urandom_range(0, 3);
            for (i = 0; i < 3; i++)
                base[i] = npcm_pkg::COLOR_W'($urandom);
            for (i = 0; i < npcm_pkg::MAX_ENTRIES; i++)
            begin
                case (style)
                    0: new_colors[i] = npcm_pkg::COLOR_W'($urandom);
                    1: new_colors[i] = {6'd0, 2'($urandom), 6'd0, 2'($urandom),
                                        6'd0, 2'($urandom)};
                    2: new_colors[i] = {{8{1'($urandom)}}, {8{1'($urandom)}},
                                        {8{1'($urandom)}}};
                    default: new_colors[i] = base[$urandom_range(0, 2)];
                endcase
            end
            write_palette(phase == 0);
            pick = $urandom_range(0, 19);
            if (pick == 0)
                cnt = 4'd0;
            else if (pick < 3)
                cnt = 4'($urandom_range(PALETTE_N + 1, 15));
            else
                cnt = 4'($urandom_range(1, PALETTE_N));
            write_reg(int'(npcm_pkg::REG_NUM_COLORS), {$urandom, 28'($urandom), cnt});
            if ($urandom_range(0, 4) == 0)
                write_reg($urandom_range(FIRST_UNUSED_REG, LAST_REG_SLOT),
                          {$urandom, $urandom});

            for (i = 0; i < PIXELS_PER_PHASE; i++)
            begin
                mode = $urandom_range(0, 9);
                col = palette_color($urandom_range(0, npcm_pkg::MAX_ENTRIES - 1));
                case (mode)
                    0, 1, 2, 3: add_pixel(npcm_pkg::COLOR_W'($urandom));
                    4, 5, 6: add_pixel({nudge(col[23:16]), nudge(col[15:8]),
                                        nudge(col[7:0])});
                    7: add_pixel({{8{1'($urandom)}}, {8{1'($urandom)}},
                                  {8{1'($urandom)}}});
                    8: add_pixel(col);
                    default: add_pixel({6'd0, 2'($urandom), 6'd0, 2'($urandom),
                                        6'd0, 2'($urandom)});
                endcase
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("streamed %0d pixels across %0d palette settings", pixels_loaded,
                 settings_count);
        $display("checked %0d results, %0d mismatches", checked_count, mismatch_count);
        if (mismatch_count == 0 && expected_colors.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/npcm_pkg.sv
hw/rtl/npcm_regs.sv
hw/rtl/npcm_cell.sv
hw/rtl/nearest_palette_color_mapper_top.sv
verif/nearest_palette_color_mapper_top_test.sv
